/* hw/rtl/bsp_pkg.sv */
// Shared types, constants and helper functions for the box support point block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bsp_pkg;

    localparam int COORD_W     = 32;
    localparam int QUAT_W      = 16;
    localparam int QUAT_FRAC   = 14;
    localparam int NUM_CORNERS = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int DOT_W       = 2 * COORD_W + 2;
    localparam int ROOT_W      = COORD_W;
    localparam int PROD_W      = 2 * COORD_W;

    localparam int CORNER_LAT  = 6;
    localparam int SELECT_LAT  = 3;
    localparam int ROOT_STEPS  = ROOT_W;
    localparam int DIV_STEPS   = COORD_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } cfg_addr_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [DOT_W-1:0]   dot_t;

    // Index 0 is x, 1 is y, 2 is z.
    typedef logic [2:0][COORD_W-1:0] vec3_t;

    typedef struct packed {
        coord_t dir_x;
        coord_t dir_y;
        coord_t dir_z;
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        quat_t  quat_w;
        quat_t  quat_x;
        quat_t  quat_y;
        quat_t  quat_z;
        coord_t margin;
    } in_item_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
    } out_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] bm;
        vec3_t              mag;
        logic [2:0]         neg;
        logic               zero;
    } root_tag_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } div_tag_t;

    // Bit i set selects the maximum for axis i, in mesh corner order.
    function automatic logic [2:0] corner_sel(input int k);
        logic [2:0] sel;
        case (k)
            0:       sel = 3'b010;
            1:       sel = 3'b110;
            2:       sel = 3'b111;
            3:       sel = 3'b011;
            4:       sel = 3'b000;
            5:       sel = 3'b100;
            6:       sel = 3'b101;
            7:       sel = 3'b001;
            default: sel = 3'b000;
        endcase
        return sel;
    endfunction

    function automatic coord_t sat32(input logic signed [63:0] x);
        coord_t res;
        if (x > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = 32'(x);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bsp_corner.sv */
// One corner lane: rotates a box corner by the quaternion, adds the position,
// saturates and forms the dot product with the direction. Depends on bsp_pkg.
`default_nettype none

module bsp_corner (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  bsp_pkg::vec3_t    corner,
    input  bsp_pkg::in_item_t item,
    output logic              out_valid,
    output bsp_pkg::dot_t     dot,
    output bsp_pkg::vec3_t    point
);
    import bsp_pkg::*;

    localparam int P1W = COORD_W + QUAT_W;
    localparam int CW  = P1W + 1 - QUAT_FRAC;
    localparam int P2W = CW + QUAT_W;
    localparam int SW  = P2W + 2;
    localparam int TW  = SW - (QUAT_FRAC - 1);
    localparam int RW  = TW + 2;
    localparam logic signed [P1W:0]  RND1 = (P1W + 1)'(1) <<< (QUAT_FRAC - 1);
    localparam logic signed [SW-1:0] RND2 = SW'(1) <<< (QUAT_FRAC - 2);

    logic                  vld_reg [CORNER_LAT];
    in_item_t              item1_reg, item2_reg, item3_reg, item4_reg;
    vec3_t                 v1_reg, v2_reg, v3_reg;
    logic signed [P1W-1:0] p1_reg [6];
    logic signed [P1W-1:0] p1_next [6];
    logic signed [CW-1:0]  c2_reg [3];
    logic signed [CW-1:0]  c2_next [3];
    logic signed [P2W-1:0] d3_reg [6];
    logic signed [P2W-1:0] d3_next [6];
    logic signed [P2W-1:0] wc3_reg [3];
    logic signed [P2W-1:0] wc3_next [3];
    vec3_t                 pt4_reg, pt4_next, pt5_reg, pt6_reg;
    logic signed [63:0]    m5_reg [3];
    logic signed [63:0]    m5_next [3];
    dot_t                  dot6_reg, dot6_next;

    always_comb begin
        p1_next[0] = P1W'(item.quat_y) * P1W'(signed'(corner[2]));
        p1_next[1] = P1W'(item.quat_z) * P1W'(signed'(corner[1]));
        p1_next[2] = P1W'(item.quat_z) * P1W'(signed'(corner[0]));
        p1_next[3] = P1W'(item.quat_x) * P1W'(signed'(corner[2]));
        p1_next[4] = P1W'(item.quat_x) * P1W'(signed'(corner[1]));
        p1_next[5] = P1W'(item.quat_y) * P1W'(signed'(corner[0]));
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c2_next[i] = CW'(((P1W + 1)'(p1_reg[2 * i]) - (P1W + 1)'(p1_reg[2 * i + 1])
                             + RND1) >>> QUAT_FRAC);
        end
    end

    always_comb begin
        d3_next[0] = P2W'(item2_reg.quat_y) * P2W'(c2_reg[2]);
        d3_next[1] = P2W'(item2_reg.quat_z) * P2W'(c2_reg[1]);
        d3_next[2] = P2W'(item2_reg.quat_z) * P2W'(c2_reg[0]);
        d3_next[3] = P2W'(item2_reg.quat_x) * P2W'(c2_reg[2]);
        d3_next[4] = P2W'(item2_reg.quat_x) * P2W'(c2_reg[1]);
        d3_next[5] = P2W'(item2_reg.quat_y) * P2W'(c2_reg[0]);
        for (int i = 0; i < 3; i++) begin
            wc3_next[i] = P2W'(item2_reg.quat_w) * P2W'(c2_reg[i]);
        end
    end

    always_comb begin
        logic signed [TW-1:0] t;
        logic signed [RW-1:0] r;
        coord_t               pos_a [3];
        pos_a[0] = item3_reg.pos_x;
        pos_a[1] = item3_reg.pos_y;
        pos_a[2] = item3_reg.pos_z;
        for (int i = 0; i < 3; i++) begin
            t = TW'((SW'(wc3_reg[i]) + SW'(d3_reg[2 * i]) - SW'(d3_reg[2 * i + 1]) + RND2)
                    >>> (QUAT_FRAC - 1));
            r = RW'(pos_a[i]) + RW'(signed'(v3_reg[i])) + RW'(t);
            pt4_next[i] = sat32(64'(r));
        end
    end

    always_comb begin
        coord_t dir_a [3];
        dir_a[0] = item4_reg.dir_x;
        dir_a[1] = item4_reg.dir_y;
        dir_a[2] = item4_reg.dir_z;
        for (int i = 0; i < 3; i++) begin
            m5_next[i] = 64'(signed'(pt4_reg[i])) * 64'(dir_a[i]);
        end
    end

    assign dot6_next = DOT_W'(m5_reg[0]) + DOT_W'(m5_reg[1]) + DOT_W'(m5_reg[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            item1_reg <= item;
            item2_reg <= item1_reg;
            item3_reg <= item2_reg;
            item4_reg <= item3_reg;
            v1_reg    <= corner;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            p1_reg    <= p1_next;
            c2_reg    <= c2_next;
            d3_reg    <= d3_next;
            wc3_reg   <= wc3_next;
            pt4_reg   <= pt4_next;
            m5_reg    <= m5_next;
            pt5_reg   <= pt4_reg;
            dot6_reg  <= dot6_next;
            pt6_reg   <= pt5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < CORNER_LAT; j++) begin
                vld_reg[j] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int j = 1; j < CORNER_LAT; j++) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    assign out_valid = vld_reg[CORNER_LAT-1];
    assign dot       = dot6_reg;
    assign point     = pt6_reg;

endmodule

`default_nettype wire

/* hw/rtl/bsp_select.sv */
// Registered compare tree that keeps the corner with the greatest dot product;
// on a tie the earlier corner wins. Depends on bsp_pkg.
`default_nettype none

module bsp_select (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  bsp_pkg::dot_t  dot [bsp_pkg::NUM_CORNERS],
    input  bsp_pkg::vec3_t pt [bsp_pkg::NUM_CORNERS],
    output logic           out_valid,
    output bsp_pkg::vec3_t point
);
    import bsp_pkg::*;

    localparam int NA = NUM_CORNERS / 2;
    localparam int NB = NA / 2;

    dot_t  da_reg [NA];
    dot_t  da_next [NA];
    vec3_t pa_reg [NA];
    vec3_t pa_next [NA];
    dot_t  db_reg [NB];
    dot_t  db_next [NB];
    vec3_t pb_reg [NB];
    vec3_t pb_next [NB];
    vec3_t pc_reg, pc_next;
    logic  vld_reg [SELECT_LAT];

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (dot[2 * i + 1] > dot[2 * i]) begin
                da_next[i] = dot[2 * i + 1];
                pa_next[i] = pt[2 * i + 1];
            end else begin
                da_next[i] = dot[2 * i];
                pa_next[i] = pt[2 * i];
            end
        end
        for (int i = 0; i < NB; i++) begin
            if (da_reg[2 * i + 1] > da_reg[2 * i]) begin
                db_next[i] = da_reg[2 * i + 1];
                pb_next[i] = pa_reg[2 * i + 1];
            end else begin
                db_next[i] = da_reg[2 * i];
                pb_next[i] = pa_reg[2 * i];
            end
        end
        if (db_reg[1] > db_reg[0]) begin
            pc_next = pb_reg[1];
        end else begin
            pc_next = pb_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            da_reg <= da_next;
            pa_reg <= pa_next;
            db_reg <= db_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < SELECT_LAT; j++) begin
                vld_reg[j] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int j = 1; j < SELECT_LAT; j++) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    assign out_valid = vld_reg[SELECT_LAT-1];
    assign point     = pc_reg;

endmodule

`default_nettype wire

/* hw/rtl/bsp_isqrt.sv */
// Pipelined integer square root of a 64-bit value, one result bit per stage,
// with a side tag carried alongside. Depends on bsp_pkg.
`default_nettype none

module bsp_isqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [63:0]         radicand,
    input  bsp_pkg::root_tag_t  in_tag,
    output logic                out_valid,
    output logic [bsp_pkg::ROOT_W-1:0] root,
    output bsp_pkg::root_tag_t  out_tag
);
    import bsp_pkg::*;

    logic [63:0] n_reg [ROOT_STEPS];
    logic [63:0] r_reg [ROOT_STEPS];
    root_tag_t   tag_reg [ROOT_STEPS];
    logic        vld_reg [ROOT_STEPS];

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_step
        localparam logic [63:0] BIT = 64'(1) << (2 * (ROOT_STEPS - 1 - g));
        logic [63:0] n_in, r_in, trial, n_next, r_next;
        logic        v_in;
        root_tag_t   t_in;

        if (g == 0) begin : g_first
            assign n_in = radicand;
            assign r_in = '0;
            assign v_in = in_valid;
            assign t_in = in_tag;
        end else begin : g_rest
            assign n_in = n_reg[g-1];
            assign r_in = r_reg[g-1];
            assign v_in = vld_reg[g-1];
            assign t_in = tag_reg[g-1];
        end

        assign trial = r_in + BIT;

        always_comb begin
            if (n_in >= trial) begin
                n_next = n_in - trial;
                r_next = (r_in >> 1) + BIT;
            end else begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[g]   <= n_next;
                r_reg[g]   <= r_next;
                tag_reg[g] <= t_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= v_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_STEPS-1];
    assign root      = r_reg[ROOT_STEPS-1][ROOT_W-1:0];
    assign out_tag   = tag_reg[ROOT_STEPS-1];

endmodule

`default_nettype wire

/* hw/rtl/bsp_div.sv */
// Pipelined restoring divider, three numerators over one shared divisor,
// one quotient bit per stage, with a side tag. Depends on bsp_pkg.
`default_nettype none

module bsp_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [bsp_pkg::PROD_W-1:0] num [3],
    input  logic [bsp_pkg::ROOT_W-1:0] den,
    input  bsp_pkg::div_tag_t          in_tag,
    output logic                       out_valid,
    output logic [bsp_pkg::COORD_W-1:0] quo [3],
    output bsp_pkg::div_tag_t          out_tag
);
    import bsp_pkg::*;

    logic [PROD_W-1:0]  rem_reg [DIV_STEPS][3];
    logic [COORD_W-1:0] quo_reg [DIV_STEPS][3];
    logic [ROOT_W-1:0]  den_reg [DIV_STEPS];
    div_tag_t           tag_reg [DIV_STEPS];
    logic               vld_reg [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        localparam int SH = DIV_STEPS - 1 - g;
        logic [PROD_W-1:0]  rem_in [3];
        logic [PROD_W-1:0]  rem_next [3];
        logic [COORD_W-1:0] quo_in [3];
        logic [COORD_W-1:0] quo_next [3];
        logic [PROD_W-1:0]  dshift;
        logic [ROOT_W-1:0]  d_in;
        logic               v_in;
        div_tag_t           t_in;

        if (g == 0) begin : g_first
            assign rem_in = num;
            assign quo_in = '{default: '0};
            assign d_in   = den;
            assign v_in   = in_valid;
            assign t_in   = in_tag;
        end else begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign d_in   = den_reg[g-1];
            assign v_in   = vld_reg[g-1];
            assign t_in   = tag_reg[g-1];
        end

        assign dshift = PROD_W'(d_in) << SH;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                if (rem_in[i] >= dshift) begin
                    rem_next[i] = rem_in[i] - dshift;
                    quo_next[i] = {quo_in[i][COORD_W-2:0], 1'b1};
                end else begin
                    rem_next[i] = rem_in[i];
                    quo_next[i] = {quo_in[i][COORD_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= rem_next;
                quo_reg[g] <= quo_next;
                den_reg[g] <= d_in;
                tag_reg[g] <= t_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= v_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign quo       = quo_reg[DIV_STEPS-1];
    assign out_tag   = tag_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

/* hw/rtl/box_support_point.sv */
// Box support point. Each transfer on the s_ channel carries a search direction,
// a body position, a Q1.14 rotation quaternion and a margin; the block returns on
// the m_ channel the rotated, translated box corner that lies furthest along the
// direction, pushed out by the margin along the unit direction and saturated to
// Q16.16. The box corners come from six configuration registers written through
// cfg_wr_en, cfg_addr and cfg_wdata; the user must write them only while the block
// is idle, and the block itself does not enforce this. The pipeline takes one item
// per cycle while the m_ channel is not stalled. The 32-stage square root and the
// 32-stage divider normalize the direction. A stalled m_ channel freezes the whole
// pipeline. Depends on bsp_pkg, bsp_corner, bsp_select, bsp_isqrt and bsp_div.
`default_nettype none

module box_support_point (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bsp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bsp_pkg::COORD_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bsp_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bsp_pkg::out_item_t            m_data
);
    import bsp_pkg::*;

    localparam int PT_DLY = 4 + ROOT_STEPS + 2 + DIV_STEPS - CORNER_LAT - SELECT_LAT;

    logic       en;
    vec3_t      box_min_reg, box_max_reg;
    in_item_t   item_reg;
    logic       item_vld_reg;

    logic [NUM_CORNERS-1:0] lane_vld;
    dot_t       lane_dot [NUM_CORNERS];
    vec3_t      lane_pt [NUM_CORNERS];
    logic       sel_vld;
    vec3_t      sel_pt;

    vec3_t      pt_dly_reg [PT_DLY];
    logic       pv_dly_reg [PT_DLY];

    vec3_t              mag1_reg, mag1_next;
    logic [COORD_W-1:0] bm1_reg, bm1_next;
    logic [2:0]         neg1_reg, neg1_next;
    logic               vld1_reg;
    root_tag_t          tag2_reg, tag2_next, tag3_reg, tag4_reg;
    logic               vld2_reg, vld3_reg, vld4_reg;
    logic [PROD_W-1:0]  sq3_reg [3];
    logic [PROD_W-1:0]  sq3_next [3];
    logic [PROD_W-1:0]  sum4_reg, sum4_next;

    logic               root_vld;
    logic [ROOT_W-1:0]  root_len;
    root_tag_t          root_tag;

    logic [PROD_W-1:0]  prod37_reg [3];
    logic [PROD_W-1:0]  prod37_next [3];
    logic [ROOT_W-1:0]  len37_reg, len38_reg;
    div_tag_t           dtag37_reg, dtag38_reg;
    logic               vld37_reg, vld38_reg;
    logic [PROD_W-1:0]  num38_reg [3];
    logic [PROD_W-1:0]  num38_next [3];

    logic               div_vld;
    logic [COORD_W-1:0] div_quo [3];
    div_tag_t           div_tag;

    logic               m_valid_reg;
    out_item_t          m_data_reg, m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_min_reg <= '0;
            box_max_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MIN_X: box_min_reg[0] <= cfg_wdata;
                CFG_MIN_Y: box_min_reg[1] <= cfg_wdata;
                CFG_MIN_Z: box_min_reg[2] <= cfg_wdata;
                CFG_MAX_X: box_max_reg[0] <= cfg_wdata;
                CFG_MAX_Y: box_max_reg[1] <= cfg_wdata;
                CFG_MAX_Z: box_max_reg[2] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= s_data;
        end
    end

    for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_lane
        localparam logic [2:0] SEL = corner_sel(k);
        vec3_t corner;

        for (genvar a = 0; a < 3; a++) begin : g_axis
            assign corner[a] = SEL[a] ? box_max_reg[a] : box_min_reg[a];
        end

        bsp_corner u_corner (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (item_vld_reg),
            .corner    (corner),
            .item      (item_reg),
            .out_valid (lane_vld[k]),
            .dot       (lane_dot[k]),
            .point     (lane_pt[k])
        );
    end

    bsp_select u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (&lane_vld),
        .dot       (lane_dot),
        .pt        (lane_pt),
        .out_valid (sel_vld),
        .point     (sel_pt)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            pt_dly_reg[0] <= sel_pt;
            for (int j = 1; j < PT_DLY; j++) begin
                pt_dly_reg[j] <= pt_dly_reg[j-1];
            end
        end
    end

    always_comb begin
        coord_t dir_a [3];
        dir_a[0] = item_reg.dir_x;
        dir_a[1] = item_reg.dir_y;
        dir_a[2] = item_reg.dir_z;
        for (int i = 0; i < 3; i++) begin
            mag1_next[i] = dir_a[i][COORD_W-1] ? (~dir_a[i]) + 32'd1 : dir_a[i];
            neg1_next[i] = dir_a[i][COORD_W-1] ^ item_reg.margin[COORD_W-1];
        end
        bm1_next = item_reg.margin[COORD_W-1] ? (~item_reg.margin) + 32'd1 : item_reg.margin;
    end

    // Scale the direction so that its largest magnitude reaches bit 30.
    always_comb begin
        logic [COORD_W-1:0] mx;
        logic [4:0]         sh;
        int                 s;
        mx = mag1_reg[0];
        if (mag1_reg[1] > mx) begin
            mx = mag1_reg[1];
        end
        if (mag1_reg[2] > mx) begin
            mx = mag1_reg[2];
        end
        tag2_next.zero = (mx == '0);
        sh = '0;
        for (int j = 0; j < 5; j++) begin
            s = 16 >> j;
            if (mx < (32'd1 << (31 - s))) begin
                mx = mx << s;
                sh = sh + 5'(s);
            end
        end
        for (int i = 0; i < 3; i++) begin
            tag2_next.mag[i] = mag1_reg[i] << sh;
        end
        tag2_next.bm  = bm1_reg;
        tag2_next.neg = neg1_reg;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq3_next[i] = PROD_W'(tag2_reg.mag[i]) * PROD_W'(tag2_reg.mag[i]);
        end
    end

    assign sum4_next = sq3_reg[0] + sq3_reg[1] + sq3_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg <= mag1_next;
            bm1_reg  <= bm1_next;
            neg1_reg <= neg1_next;
            tag2_reg <= tag2_next;
            tag3_reg <= tag2_reg;
            sq3_reg  <= sq3_next;
            tag4_reg <= tag3_reg;
            sum4_reg <= sum4_next;
        end
    end

    bsp_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld4_reg),
        .radicand  (sum4_reg),
        .in_tag    (tag4_reg),
        .out_valid (root_vld),
        .root      (root_len),
        .out_tag   (root_tag)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod37_next[i] = PROD_W'(root_tag.bm) * PROD_W'(root_tag.mag[i]);
            num38_next[i]  = prod37_reg[i] + PROD_W'(len37_reg >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod37_reg      <= prod37_next;
            len37_reg       <= root_len;
            dtag37_reg.neg  <= root_tag.neg;
            dtag37_reg.zero <= root_tag.zero;
            num38_reg       <= num38_next;
            len38_reg       <= len37_reg;
            dtag38_reg      <= dtag37_reg;
        end
    end

    bsp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld38_reg),
        .num       (num38_reg),
        .den       (len38_reg),
        .in_tag    (dtag38_reg),
        .out_valid (div_vld),
        .quo       (div_quo),
        .out_tag   (div_tag)
    );

    always_comb begin
        logic signed [63:0] off;
        coord_t             res [3];
        for (int i = 0; i < 3; i++) begin
            off = signed'(64'(div_quo[i]));
            if (div_tag.zero) begin
                off = '0;
            end else if (div_tag.neg[i]) begin
                off = -off;
            end
            res[i] = sat32(64'(signed'(pt_dly_reg[PT_DLY-1][i])) + off);
        end
        m_data_next.point_x = res[0];
        m_data_next.point_y = res[1];
        m_data_next.point_z = res[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
            vld1_reg     <= 1'b0;
            vld2_reg     <= 1'b0;
            vld3_reg     <= 1'b0;
            vld4_reg     <= 1'b0;
            vld37_reg    <= 1'b0;
            vld38_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int j = 0; j < PT_DLY; j++) begin
                pv_dly_reg[j] <= 1'b0;
            end
        end else if (en) begin
            item_vld_reg  <= s_valid;
            vld1_reg      <= item_vld_reg;
            vld2_reg      <= vld1_reg;
            vld3_reg      <= vld2_reg;
            vld4_reg      <= vld3_reg;
            vld37_reg     <= root_vld;
            vld38_reg     <= vld37_reg;
            pv_dly_reg[0] <= sel_vld;
            for (int j = 1; j < PT_DLY; j++) begin
                pv_dly_reg[j] <= pv_dly_reg[j-1];
            end
            m_valid_reg   <= div_vld && pv_dly_reg[PT_DLY-1];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/bsp_checker.sv */
// Port-level checks for box_support_point and the bind that attaches them.
// Depends on bsp_pkg and box_support_point.
`default_nettype none

module bsp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input bsp_pkg::out_item_t m_data
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid did not clear after reset.");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result changed before its transfer.");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("Input ready does not follow the output stall.");

endmodule

bind box_support_point bsp_checker u_bsp_checker (.*);

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for box_support_point: drives random and directed queries,
// predicts each support point, and compares every returned point field by field.
// Depends on bsp_pkg and the box_support_point RTL.

module testbench;
    import bsp_pkg::*;

    class support_scoreboard;
        longint    box_min[3];
        longint    box_max[3];
        out_item_t expected_points[$];
        int        errors;
        int        checked;

        function new();
            for (int i = 0; i < 3; i++) begin
                box_min[i] = 0;
                box_max[i] = 0;
            end
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(cfg_addr_t idx, logic [31:0] val);
            if (idx <= CFG_MIN_Z) begin
                box_min[int'(idx)] = longint'($signed(val));
            end else begin
                box_max[int'(idx) - 3] = longint'($signed(val));
            end
        endfunction

        static function longint clamp32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // Round to nearest, ties toward plus infinity.
        static function longint round_shift(longint x, int n);
            longint half;
            half = longint'(1) <<< (n - 1);
            return (x + half) >>> n;
        endfunction

        static function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function out_item_t predict_point(in_item_t it);
            longint          dir[3], pos[3], v[3], c[3], d[3], pt[3], best[3];
            longint          w, ux, uy, uz, marg, off;
            logic signed [65:0] dot, best_dot;
            logic [2:0]      sel;
            longint unsigned mag[3], mx, sq, len, bm, qv;
            logic            neg;
            out_item_t       res;
            dir[0] = it.dir_x; dir[1] = it.dir_y; dir[2] = it.dir_z;
            pos[0] = it.pos_x; pos[1] = it.pos_y; pos[2] = it.pos_z;
            w = it.quat_w; ux = it.quat_x; uy = it.quat_y; uz = it.quat_z;
            marg = it.margin;
            best_dot = '0;
            for (int k = 0; k < 8; k++) begin
                sel = corner_sel(k);
                for (int i = 0; i < 3; i++) v[i] = sel[i] ? box_max[i] : box_min[i];
                c[0] = round_shift(uy * v[2] - uz * v[1], QUAT_FRAC);
                c[1] = round_shift(uz * v[0] - ux * v[2], QUAT_FRAC);
                c[2] = round_shift(ux * v[1] - uy * v[0], QUAT_FRAC);
                d[0] = uy * c[2] - uz * c[1];
                d[1] = uz * c[0] - ux * c[2];
                d[2] = ux * c[1] - uy * c[0];
                dot = '0;
                for (int i = 0; i < 3; i++) begin
                    pt[i] = clamp32(pos[i] + v[i] + round_shift(w * c[i] + d[i], QUAT_FRAC - 1));
                    dot = dot + 66'(pt[i] * dir[i]);
                end
                if (k == 0 || dot > best_dot) begin
                    best_dot = dot;
                    for (int i = 0; i < 3; i++) best[i] = pt[i];
                end
            end
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = dir[i] < 0 ? longint'(-dir[i]) : longint'(dir[i]);
                if (mag[i] > mx) mx = mag[i];
            end
            if (mx != 0) begin
                while (mx < (64'd1 << 30)) begin
                    mx = mx << 1;
                    for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
                end
                sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
                len = int_sqrt(sq);
                bm = marg < 0 ? longint'(-marg) : longint'(marg);
                for (int i = 0; i < 3; i++) begin
                    qv = (bm * mag[i] + len / 2) / len;
                    neg = (marg < 0) != (dir[i] < 0);
                    off = neg ? -longint'(qv) : longint'(qv);
                    best[i] = clamp32(best[i] + off);
                end
            end
            res.point_x = best[0][31:0];
            res.point_y = best[1][31:0];
            res.point_z = best[2][31:0];
            return res;
        endfunction

        function void note_query(in_item_t it);
            expected_points = {expected_points, predict_point(it)};
        endfunction

        function void check_point(out_item_t got);
            out_item_t exp_pt;
            if (expected_points.size() == 0) begin
                $error("point returned with no query outstanding");
                errors++;
                return;
            end
            exp_pt = expected_points.pop_front();
            checked++;
            if (got.point_x !== exp_pt.point_x) begin
                $error("point_x expected %0d got %0d", exp_pt.point_x, got.point_x);
                errors++;
            end
            if (got.point_y !== exp_pt.point_y) begin
                $error("point_y expected %0d got %0d", exp_pt.point_y, got.point_y);
                errors++;
            end
            if (got.point_z !== exp_pt.point_z) begin
                $error("point_z expected %0d got %0d", exp_pt.point_z, got.point_z);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [COORD_W-1:0] cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;

    support_scoreboard sb;
    int  send_idle;
    int  recv_idle;
    int  hold_left;
    bit  hold_req;
    int  quiet_cycles;
    int  sent;

    box_support_point dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Receiver side: random back-pressure plus requested long hold-offs.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_query(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_point(m_data);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    function automatic coord_t pick_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(32'h0020_0000) - 32'h0010_0000);
            2: return 32'sh7fffffff;
            3: return 32'sh80000000;
            default: return coord_t'($urandom_range(32'h0800_0000) - 32'h0400_0000);
        endcase
    endfunction

    function automatic in_item_t rand_query();
        in_item_t it;
        int       axis;
        it.dir_x = pick_coord();
        it.dir_y = pick_coord();
        it.dir_z = pick_coord();
        case ($urandom_range(9))
            0: begin
                it.dir_x = '0; it.dir_y = '0; it.dir_z = '0;
            end
            1, 2: begin
                axis = $urandom_range(2);
                if (axis != 0) it.dir_x = '0;
                if (axis != 1) it.dir_y = '0;
                if (axis != 2) it.dir_z = '0;
            end
            default: ;
        endcase
        it.pos_x = pick_coord();
        it.pos_y = pick_coord();
        it.pos_z = pick_coord();
        case ($urandom_range(4))
            0: begin
                it.quat_w = 16384; it.quat_x = 0; it.quat_y = 0; it.quat_z = 0;
            end
            1: begin
                it.quat_w = 11585; it.quat_x = 0; it.quat_y = 0; it.quat_z = 0;
                case ($urandom_range(2))
                    0: it.quat_x = $urandom_range(1) ? 11585 : -11585;
                    1: it.quat_y = $urandom_range(1) ? 11585 : -11585;
                    default: it.quat_z = $urandom_range(1) ? 11585 : -11585;
                endcase
            end
            2: begin
                it.quat_w = 8192; it.quat_x = 8192; it.quat_y = -8192; it.quat_z = 8192;
            end
            default: begin
                it.quat_w = $urandom_range(32768) - 16384;
                it.quat_x = $urandom_range(32768) - 16384;
                it.quat_y = $urandom_range(32768) - 16384;
                it.quat_z = $urandom_range(32768) - 16384;
            end
        endcase
        if ($urandom_range(3) == 0) begin
            it.margin = pick_coord();
        end else begin
            it.margin = coord_t'($urandom_range(32'h0004_0000) - 32'h0002_0000);
        end
        return it;
    endfunction

    function automatic in_item_t make_query(coord_t dx, coord_t dy, coord_t dz,
                                            coord_t px, quat_t qw, quat_t qx,
                                            quat_t qy, quat_t qz, coord_t mg);
        in_item_t it;
        it.dir_x = dx; it.dir_y = dy; it.dir_z = dz;
        it.pos_x = px; it.pos_y = -px; it.pos_z = px;
        it.quat_w = qw; it.quat_x = qx; it.quat_y = qy; it.quat_z = qz;
        it.margin = mg;
        return it;
    endfunction

    task automatic send_query(in_item_t it);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_points.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_box(coord_t mn[3], coord_t mx[3]);
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr <= cfg_addr_t'(i);
            cfg_wdata <= (i < 3) ? mn[i] : mx[i - 3];
            sb.set_reg(cfg_addr_t'(i), (i < 3) ? mn[i] : mx[i - 3]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        coord_t mn[3];
        coord_t mx[3];
        coord_t t;
        sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        send_idle = 29;
        recv_idle = 56;
        hold_left = 0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 4; i++) send_query(rand_query());
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            send_idle = (ph < 2) ? 29 : (ph < 4) ? 56 : 0;
            recv_idle = (ph < 2) ? 56 : (ph < 4) ? 29 : 0;
            for (int i = 0; i < 3; i++) begin
                case (ph)
                    0: begin
                        mn[i] = -32'sd98304 + 32'sd32768 * i;
                        mx[i] = 32'sd65536 + 32'sd65536 * i;
                    end
                    1: begin
                        mn[i] = 32'sh80000000;
                        mx[i] = 32'sh7fffffff;
                    end
                    2: begin
                        mn[i] = pick_coord();
                        mx[i] = pick_coord();
                        if (mn[i] < mx[i]) begin
                            t = mn[i]; mn[i] = mx[i]; mx[i] = t;
                        end
                    end
                    3: begin
                        mn[i] = coord_t'($urandom);
                        mx[i] = coord_t'($urandom);
                    end
                    4: begin
                        mn[i] = coord_t'($urandom_range(32'h0004_0000) - 32'h0004_0000);
                        mx[i] = coord_t'($urandom_range(32'h0004_0000));
                    end
                    default: begin
                        mn[i] = 32'sh7fffffff;
                        mx[i] = 32'sh80000000;
                    end
                endcase
            end
            write_box(mn, mx);

            if (ph == 0) begin
                send_query(make_query(0, 0, 0, 0, 16384, 0, 0, 0, 32'sd65536));
                send_query(make_query(32'sd65536, 0, 0, 0, 16384, 0, 0, 0, 0));
                send_query(make_query(-32'sd65536, 0, 0, 0, 16384, 0, 0, 0, 0));
                send_query(make_query(0, 32'sd65536, 0, 32'sd65536, 16384, 0, 0, 0, 0));
                send_query(make_query(0, -32'sd65536, 0, 0, 16384, 0, 0, 0, 32'sd65536));
                send_query(make_query(0, 0, 32'sd65536, 0, 16384, 0, 0, 0, -32'sd65536));
                send_query(make_query(0, 0, -32'sd65536, 0, 16384, 0, 0, 0, 0));
                send_query(make_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                      32'sh7fffffff, 16384, 0, 0, 0, 32'sh7fffffff));
                send_query(make_query(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      32'sh80000000, 16384, 0, 0, 0, 32'sh80000000));
                send_query(make_query(32'sh80000000, 32'sh7fffffff, 1, 0,
                                      16384, 0, 0, 0, 32'sh7fffffff));
                send_query(make_query(1, 1, 1, 0, 11585, 0, 0, 11585, 32'sd1000));
                send_query(make_query(1, -1, 1, 0, 11585, 11585, 0, 0, 32'sd1000));
                send_query(make_query(-3, 5, 7, 0, 16384, 16384, 16384, 16384, 32'sd65536));
                send_query(make_query(5, 7, -3, 32'sd1000, -16384, -16384, -16384, -16384,
                                      -32'sd65536));
                send_query(make_query(32'sd65536, 32'sd65536, 0, 0, 0, 0, 0, 16384, 0));
                send_query(make_query(32'sd65536, 0, 0, 0, 0, 0, 0, 0, 32'sd65536));
                send_query(make_query(0, 0, 0, 32'sh7fffffff, 16384, 16384, 0, 0, 0));
                send_query(make_query(32'sd1, 32'sd2, 32'sd3, 0, 8192, 8192, -8192, 8192,
                                      32'sh7fffffff));
            end

            for (int n = 0; n < 280; n++) begin
                if (ph == 1 && n == 40) hold_req = 1'b1;
                if (ph == 2 && n == 140) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (sb.expected_points.size() != 0) @(posedge aclk);
                end
                send_query(rand_query());
            end
            drain();
        end

        $display("Sent %0d queries over 7 box settings, checked %0d support points.",
                 sent, sb.checked);
        $display("Covered reset, extreme, inverted and random boxes under three idle mixes.");
        if (sb.errors == 0 && sb.expected_points.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
